[rtl/ihsp_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ihsp_pkg
// Shared types and constants of the image header size probe.
// ----------------------------------------------------------------------------
package ihsp_pkg;

  localparam int POSITION_BITS_DEF = 32;
  localparam int STORE_DEPTH       = 30;
  localparam int STORE_IDX_BITS    = $clog2(STORE_DEPTH);

  // image kind codes
  localparam logic [2:0] KIND_NONE = 3'd0;
  localparam logic [2:0] KIND_PNG  = 3'd1;
  localparam logic [2:0] KIND_JPEG = 3'd2;
  localparam logic [2:0] KIND_GIF  = 3'd3;
  localparam logic [2:0] KIND_WEBP = 3'd4;

  // signature bytes and tags
  localparam logic [63:0] SIG_PNG   = 64'h89504e470d0a1a0a;
  localparam logic [31:0] TAG_IHDR  = 32'h49484452;
  localparam logic [31:0] TAG_GIF8  = 32'h47494638;
  localparam logic [7:0]  GIF_VER7  = 8'h37;
  localparam logic [7:0]  GIF_VER9  = 8'h39;
  localparam logic [7:0]  GIF_LET_A = 8'h61;
  localparam logic [31:0] TAG_RIFF  = 32'h52494646;
  localparam logic [31:0] TAG_WEBP  = 32'h57454250;
  localparam logic [31:0] TAG_VP8   = 32'h56503820;
  localparam logic [31:0] TAG_VP8L  = 32'h5650384c;
  localparam logic [31:0] TAG_VP8X  = 32'h56503858;
  localparam logic [23:0] VP8_START = 24'h9d012a;
  localparam logic [7:0]  VP8L_SIG  = 8'h2f;
  localparam logic [15:0] DIM14_MASK = 16'h3fff;

  // jpeg markers
  localparam logic [7:0] JPG_FILL = 8'hff;
  localparam logic [7:0] JPG_SOI  = 8'hd8;
  localparam logic [7:0] JPG_EOI  = 8'hd9;
  localparam logic [7:0] JPG_RST0 = 8'hd0;
  localparam logic [7:0] JPG_TEM  = 8'h01;
  localparam logic [7:0] JPG_SOF0 = 8'hc0;
  localparam logic [7:0] JPG_SOFF = 8'hcf;
  localparam logic [7:0] JPG_DHT  = 8'hc4;
  localparam logic [7:0] JPG_JPG  = 8'hc8;
  localparam logic [7:0] JPG_DAC  = 8'hcc;

  typedef logic [STORE_DEPTH-1:0][7:0] hdr_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_file;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  image_kind;
    logic [31:0] pixel_width;
    logic [31:0] pixel_height;
  } out_word_t;

  typedef struct packed {
    logic        found;
    logic [15:0] width;
    logic [15:0] height;
  } jpeg_res_t;

endpackage : ihsp_pkg
`default_nettype wire

[rtl/ihsp_walker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ihsp_walker
// JPEG marker walker: follows the marker stream byte by byte up to the first
// start-of-frame header and picks out the frame size.
// ----------------------------------------------------------------------------
module ihsp_walker
  import ihsp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       step,
  input  wire logic       clear,
  input  wire logic [7:0] data_byte,
  output jpeg_res_t       jpeg_res
);

  typedef enum logic [5:0] {
    PH_START   = 6'b000001,
    PH_FILL    = 6'b000010,
    PH_LEN_HI  = 6'b000100,
    PH_LEN_LO  = 6'b001000,
    PH_SKIP    = 6'b010000,
    PH_FRAME   = 6'b100000
  } walk_phase_t;

  typedef enum logic [2:0] {
    WO_PENDING = 3'b001,
    WO_FOUND   = 3'b010,
    WO_FAILED  = 3'b100
  } walk_outcome_t;

  walk_phase_t   phase_r, phase_nxt;
  walk_outcome_t outcome_r, outcome_nxt;
  logic [15:0]   skip_r, skip_nxt;
  logic [7:0]    marker_r, marker_nxt;
  logic [7:0]    len_hi_r, len_hi_nxt;
  logic [15:0]   fw_r, fw_nxt;
  logic [15:0]   fh_r, fh_nxt;

  logic [15:0] seg_len;
  logic        alone;
  logic        sof;

  assign seg_len = {len_hi_r, data_byte};
  assign alone   = (data_byte == JPG_TEM) ||
                   (data_byte >= JPG_RST0 && data_byte <= JPG_EOI);
  assign sof     = (marker_r >= JPG_SOF0) && (marker_r <= JPG_SOFF) &&
                   (marker_r != JPG_DHT) && (marker_r != JPG_JPG) &&
                   (marker_r != JPG_DAC);

  always_comb begin
    phase_nxt   = phase_r;
    outcome_nxt = outcome_r;
    skip_nxt    = skip_r;
    marker_nxt  = marker_r;
    len_hi_nxt  = len_hi_r;
    fw_nxt      = fw_r;
    fh_nxt      = fh_r;
    if (step && outcome_r == WO_PENDING) begin
      case (phase_r)
        PH_START: begin
          if (data_byte != JPG_FILL) begin
            outcome_nxt = WO_FAILED;
          end else begin
            phase_nxt = PH_FILL;
          end
        end
        PH_FILL: begin
          if (data_byte != JPG_FILL) begin
            marker_nxt = data_byte;
            phase_nxt  = alone ? PH_START : PH_LEN_HI;
          end
        end
        PH_LEN_HI: begin
          len_hi_nxt = data_byte;
          phase_nxt  = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          if (seg_len < 16'd2) begin
            outcome_nxt = WO_FAILED;
          end else if (sof) begin
            skip_nxt  = '0;
            phase_nxt = PH_FRAME;
          end else if (seg_len == 16'd2) begin
            phase_nxt = PH_START;
          end else begin
            skip_nxt  = seg_len - 16'd2;
            phase_nxt = PH_SKIP;
          end
        end
        PH_SKIP: begin
          skip_nxt = skip_r - 16'd1;
          if (skip_r == 16'd1) begin
            phase_nxt = PH_START;
          end
        end
        PH_FRAME: begin
          case (skip_r)
            16'd1: fh_nxt = {data_byte, 8'h00};
            16'd2: fh_nxt = fh_r | {8'h00, data_byte};
            16'd3: fw_nxt = {data_byte, 8'h00};
            16'd4: begin
              fw_nxt      = fw_r | {8'h00, data_byte};
              outcome_nxt = WO_FOUND;
            end
            default: ;
          endcase
          skip_nxt = skip_r + 16'd1;
        end
        default: outcome_nxt = WO_FAILED;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      phase_r   <= PH_START;
      outcome_r <= WO_PENDING;
      skip_r    <= '0;
      marker_r  <= '0;
      len_hi_r  <= '0;
      fw_r      <= '0;
      fh_r      <= '0;
    end else begin
      phase_r   <= phase_nxt;
      outcome_r <= outcome_nxt;
      skip_r    <= skip_nxt;
      marker_r  <= marker_nxt;
      len_hi_r  <= len_hi_nxt;
      fw_r      <= fw_nxt;
      fh_r      <= fh_nxt;
    end
  end

  // the classifier sees the walk including the current byte
  assign jpeg_res.found  = (outcome_nxt == WO_FOUND);
  assign jpeg_res.width  = fw_nxt;
  assign jpeg_res.height = fh_nxt;

endmodule : ihsp_walker
`default_nettype wire

[rtl/ihsp_classify.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ihsp_classify
// Format decision and size extraction from the header bytes of one file.
// ----------------------------------------------------------------------------
module ihsp_classify
  import ihsp_pkg::*;
(
  input  wire hdr_t                hdr,
  input  wire logic [4:0]          last_idx,
  input  wire jpeg_res_t           jpeg_res,
  output out_word_t                result
);

  logic [31:0] tag0, tag8, tag12, vp8l_bits;
  logic [63:0] sig8;
  logic        is_png, is_jpeg, is_gif, is_riff;
  logic [15:0] vp8_w, vp8_h;
  logic [23:0] vp8x_w, vp8x_h;

  assign sig8  = {hdr[0], hdr[1], hdr[2], hdr[3], hdr[4], hdr[5], hdr[6], hdr[7]};
  assign tag0  = {hdr[0], hdr[1], hdr[2], hdr[3]};
  assign tag8  = {hdr[8], hdr[9], hdr[10], hdr[11]};
  assign tag12 = {hdr[12], hdr[13], hdr[14], hdr[15]};

  assign is_png  = (last_idx >= 5'd23) && (sig8 == SIG_PNG) && (tag12 == TAG_IHDR);
  assign is_jpeg = (last_idx >= 5'd3) && (hdr[0] == JPG_FILL) && (hdr[1] == JPG_SOI) &&
                   jpeg_res.found;
  assign is_gif  = (last_idx >= 5'd9) && (tag0 == TAG_GIF8) &&
                   ((hdr[4] == GIF_VER7) || (hdr[4] == GIF_VER9)) && (hdr[5] == GIF_LET_A);
  assign is_riff = (last_idx >= 5'd15) && (tag0 == TAG_RIFF) && (tag8 == TAG_WEBP);

  assign vp8_w     = {hdr[27], hdr[26]} & DIM14_MASK;
  assign vp8_h     = {hdr[29], hdr[28]} & DIM14_MASK;
  assign vp8l_bits = {hdr[24], hdr[23], hdr[22], hdr[21]};
  assign vp8x_w    = {hdr[26], hdr[25], hdr[24]};
  assign vp8x_h    = {hdr[29], hdr[28], hdr[27]};

  always_comb begin
    result = '{image_kind: KIND_NONE, pixel_width: '0, pixel_height: '0};
    if (is_png) begin
      result.image_kind   = KIND_PNG;
      result.pixel_width  = {hdr[16], hdr[17], hdr[18], hdr[19]};
      result.pixel_height = {hdr[20], hdr[21], hdr[22], hdr[23]};
    end else if (is_jpeg) begin
      result.image_kind   = KIND_JPEG;
      result.pixel_width  = {16'h0000, jpeg_res.width};
      result.pixel_height = {16'h0000, jpeg_res.height};
    end else if (is_gif) begin
      result.image_kind   = KIND_GIF;
      result.pixel_width  = {16'h0000, hdr[7], hdr[6]};
      result.pixel_height = {16'h0000, hdr[9], hdr[8]};
    end else if (is_riff) begin
      if (tag12 == TAG_VP8) begin
        if (last_idx >= 5'd29 && {hdr[23], hdr[24], hdr[25]} == VP8_START) begin
          result.image_kind   = KIND_WEBP;
          result.pixel_width  = {16'h0000, vp8_w};
          result.pixel_height = {16'h0000, vp8_h};
        end
      end else if (tag12 == TAG_VP8L) begin
        if (last_idx >= 5'd24 && hdr[20] == VP8L_SIG) begin
          result.image_kind   = KIND_WEBP;
          result.pixel_width  = {18'h0, vp8l_bits[13:0]} + 32'd1;
          result.pixel_height = {18'h0, vp8l_bits[27:14]} + 32'd1;
        end
      end else if (tag12 == TAG_VP8X) begin
        if (last_idx >= 5'd29) begin
          result.image_kind   = KIND_WEBP;
          result.pixel_width  = {8'h00, vp8x_w} + 32'd1;
          result.pixel_height = {8'h00, vp8x_h} + 32'd1;
        end
      end
    end
  end

endmodule : ihsp_classify
`default_nettype wire

[rtl/image_header_size_probe_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// image_header_size_probe_top
// Sniffs png, jpeg, gif and webp headers and reports the pixel size.
//
// Usage: the bytes of one file enter on in_word, one word per accepted
// in_valid/in_stall handshake, with end_of_file set on the final byte. That
// byte yields one result word on out_word (kind, width, height); other bytes
// yield none, and the next byte after it starts a new file.
// Throughput: one byte per clock cycle while in_stall is low. Each byte sits in the input
// register, where the position counter, the header byte store and the jpeg
// marker walker are updated and, for the final byte, the result is formed.
// Result: it is loaded into the output register when the final byte leaves
// the input register.
// Stall: a waiting result does not block following bytes of the next file;
// only a final byte that finds the output register still full and stalled
// holds the input register, and in_stall rises then.
// Reset: clears position, walker and handshake state; no result pending.
// ----------------------------------------------------------------------------
module image_header_size_probe_top
  import ihsp_pkg::*;
#(
  parameter int POSITION_BITS = POSITION_BITS_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_word_t in_word,
  output logic          out_valid,
  input  wire logic     out_stall,
  output out_word_t     out_word
);

  logic                     s1_valid_r;
  in_word_t                 s1_word_r;
  logic                     s1_adv;
  logic                     out_valid_r;
  out_word_t                out_word_r;
  out_word_t                result;
  logic                     out_load;
  logic [POSITION_BITS-1:0] pos_r;
  logic                     pos_in_store;
  logic [4:0]               last_idx;
  logic [7:0]               store_r [STORE_DEPTH];
  hdr_t                     hdr_view;
  jpeg_res_t                jpeg_res;

  // a final byte waits only when the result slot is full and stalled
  assign s1_adv   = s1_valid_r &&
                    !(s1_word_r.end_of_file && out_valid_r && out_stall);
  assign in_stall = s1_valid_r && !s1_adv;
  assign out_load = s1_adv && s1_word_r.end_of_file;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_word_r <= in_word;
    end
  end

  // byte position, saturating
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else if (s1_adv) begin
      if (s1_word_r.end_of_file) begin
        pos_r <= '0;
      end else if (pos_r != '1) begin
        pos_r <= pos_r + 1'b1;
      end
    end
  end

  assign pos_in_store = (pos_r < POSITION_BITS'(STORE_DEPTH));
  assign last_idx     = (pos_r >= POSITION_BITS'(31)) ? 5'd31 : pos_r[4:0];

  always_ff @(posedge clk) begin
    if (s1_adv && pos_in_store) begin
      store_r[pos_r[STORE_IDX_BITS-1:0]] <= s1_word_r.data_byte;
    end
  end

  // header as seen including the byte being processed
  always_comb begin
    for (int i = 0; i < STORE_DEPTH; i++) begin
      if (pos_in_store && pos_r[STORE_IDX_BITS-1:0] == STORE_IDX_BITS'(i)) begin
        hdr_view[i] = s1_word_r.data_byte;
      end else begin
        hdr_view[i] = store_r[i];
      end
    end
  end

  ihsp_walker u_walker (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (s1_adv && (pos_r >= POSITION_BITS'(2))),
    .clear     (out_load),
    .data_byte (s1_word_r.data_byte),
    .jpeg_res  (jpeg_res)
  );

  ihsp_classify u_classify (
    .hdr      (hdr_view),
    .last_idx (last_idx),
    .jpeg_res (jpeg_res),
    .result   (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_word_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  a_final_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_valid_r)
    else $error("final byte did not load a result");

  a_hold_only_final: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_adv) |-> (s1_word_r.end_of_file && out_valid_r && out_stall))
    else $error("input register held without a blocked result");

  a_new_file_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (pos_r == '0))
    else $error("position not cleared after final byte");

  a_none_zero_size: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_word_r.image_kind == KIND_NONE) |->
      (out_word_r.pixel_width == '0 && out_word_r.pixel_height == '0))
    else $error("unrecognized file with nonzero size");

endmodule : image_header_size_probe_top
`default_nettype wire

[bench/image_header_size_probe_top_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// image_header_size_probe_top_test
// Streams whole image files (png, jpeg, gif, webp, noise) byte by byte into
// the size probe, some well formed, some corrupted or cut short, and checks
// each end-of-file result word against a cycle-free model of the sniffer.
// Both channels see random idling and stall in three load stages.
// ----------------------------------------------------------------------------
module image_header_size_probe_top_test
  import ihsp_pkg::*;
;

  localparam int QUIET_LIMIT = 2000;
  localparam logic [7:0] JPG_RST7 = 8'hd7;
  localparam logic [7:0] JPG_APP0 = 8'he0;

  typedef enum logic [2:0] {
    WALK_FILL_WAIT = 3'd0,
    WALK_IN_FILL   = 3'd1,
    WALK_LEN_HI    = 3'd2,
    WALK_LEN_LO    = 3'd3,
    WALK_SKIP      = 3'd4,
    WALK_FRAME     = 3'd5
  } walk_phase_t;

  typedef enum logic [1:0] {
    WALK_PENDING = 2'd0,
    WALK_FOUND   = 2'd1,
    WALK_FAILED  = 2'd2
  } walk_result_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_word_t  in_word = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_word;

  image_header_size_probe_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  always #1 clk = ~clk;

  // stimulus and scoreboard
  in_word_t  pending_bytes[$];
  logic [7:0] file_q[$];
  out_word_t expected_sizes[$];
  out_word_t want;
  int file_count = 0;
  int in_total = 1;
  int in_accepted = 0;
  int out_accepted = 0;
  int error_count = 0;
  int quiet_cycles = 0;
  int kinds_seen[8] = '{default: 0};

  // sniffer model state
  logic [31:0]  probe_pos = '0;
  logic [7:0]   probe_hdr[STORE_DEPTH] = '{default: 8'h00};
  walk_phase_t  walk_phase = WALK_FILL_WAIT;
  logic [15:0]  walk_count = '0;
  logic [7:0]   walk_marker = '0;
  logic [7:0]   walk_len_hi = '0;
  logic [15:0]  walk_fw = '0;
  logic [15:0]  walk_fh = '0;
  walk_result_t walk_result = WALK_PENDING;

  task automatic report_mismatch(string what);
    $display("[%0t] mismatch: %s", $time, what);
    error_count++;
  endtask

  function automatic logic is_standalone(logic [7:0] m);
    return m == JPG_SOI || m == JPG_EOI || m == JPG_TEM || (m >= JPG_RST0 && m <= JPG_RST7);
  endfunction

  function automatic logic is_frame_marker(logic [7:0] m);
    return m >= JPG_SOF0 && m <= JPG_SOFF && m != JPG_DHT && m != JPG_JPG && m != JPG_DAC;
  endfunction

  function automatic void clear_file_state();
    probe_pos   = '0;
    walk_phase  = WALK_FILL_WAIT;
    walk_count  = '0;
    walk_marker = '0;
    walk_len_hi = '0;
    walk_fw     = '0;
    walk_fh     = '0;
    walk_result = WALK_PENDING;
  endfunction

  function automatic void walk_marker_byte(logic [7:0] b);
    logic [15:0] seg_len;
    if (walk_result != WALK_PENDING) return;
    case (walk_phase)
      WALK_FILL_WAIT: begin
        if (b != JPG_FILL) walk_result = WALK_FAILED;
        else walk_phase = WALK_IN_FILL;
      end
      WALK_IN_FILL: begin
        if (b != JPG_FILL) begin
          walk_marker = b;
          if (is_standalone(b)) walk_phase = WALK_FILL_WAIT;
          else walk_phase = WALK_LEN_HI;
        end
      end
      WALK_LEN_HI: begin
        walk_len_hi = b;
        walk_phase = WALK_LEN_LO;
      end
      WALK_LEN_LO: begin
        seg_len = {walk_len_hi, b};
        if (seg_len < 16'd2) begin
          walk_result = WALK_FAILED;
        end else if (is_frame_marker(walk_marker)) begin
          walk_count = '0;
          walk_phase = WALK_FRAME;
        end else if (seg_len == 16'd2) begin
          walk_phase = WALK_FILL_WAIT;
        end else begin
          walk_count = seg_len - 16'd2;
          walk_phase = WALK_SKIP;
        end
      end
      WALK_SKIP: begin
        walk_count = walk_count - 16'd1;
        if (walk_count == 16'd0) walk_phase = WALK_FILL_WAIT;
      end
      WALK_FRAME: begin
        // offset 0 is the sample precision byte
        case (walk_count)
          16'd1: walk_fh = {b, 8'h00};
          16'd2: walk_fh = walk_fh | {8'h00, b};
          16'd3: walk_fw = {b, 8'h00};
          16'd4: begin
            walk_fw = walk_fw | {8'h00, b};
            walk_result = WALK_FOUND;
          end
          default: ;
        endcase
        walk_count = walk_count + 16'd1;
      end
      default: walk_result = WALK_FAILED;
    endcase
  endfunction

  function automatic logic tag_at(int i, logic [31:0] tag);
    for (int k = 0; k < 4; k++)
      if (probe_hdr[i + k] != tag[31 - 8 * k -: 8]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic logic [31:0] le_at(int i, int n);
    logic [31:0] v;
    v = '0;
    for (int k = 0; k < n; k++) v = v | (32'(probe_hdr[i + k]) << (8 * k));
    return v;
  endfunction

  function automatic logic [31:0] be32_at(int i);
    return {probe_hdr[i], probe_hdr[i + 1], probe_hdr[i + 2], probe_hdr[i + 3]};
  endfunction

  // end_pos is the index of the final byte
  function automatic out_word_t classify_header(logic [31:0] end_pos);
    out_word_t r;
    logic [31:0] bits;
    r = '0;
    if (end_pos >= 23 && tag_at(0, SIG_PNG[63:32]) && tag_at(4, SIG_PNG[31:0])
        && tag_at(12, TAG_IHDR)) begin
      r.image_kind   = KIND_PNG;
      r.pixel_width  = be32_at(16);
      r.pixel_height = be32_at(20);
    end else if (end_pos >= 3 && probe_hdr[0] == JPG_FILL && probe_hdr[1] == JPG_SOI
                 && walk_result == WALK_FOUND) begin
      r.image_kind   = KIND_JPEG;
      r.pixel_width  = {16'h0, walk_fw};
      r.pixel_height = {16'h0, walk_fh};
    end else if (end_pos >= 9 && tag_at(0, TAG_GIF8)
                 && (probe_hdr[4] == GIF_VER7 || probe_hdr[4] == GIF_VER9)
                 && probe_hdr[5] == GIF_LET_A) begin
      r.image_kind   = KIND_GIF;
      r.pixel_width  = le_at(6, 2);
      r.pixel_height = le_at(8, 2);
    end else if (end_pos >= 15 && tag_at(0, TAG_RIFF) && tag_at(8, TAG_WEBP)) begin
      if (tag_at(12, TAG_VP8)) begin
        if (end_pos >= 29 && {probe_hdr[23], probe_hdr[24], probe_hdr[25]} == VP8_START) begin
          r.image_kind   = KIND_WEBP;
          r.pixel_width  = le_at(26, 2) & {16'h0, DIM14_MASK};
          r.pixel_height = le_at(28, 2) & {16'h0, DIM14_MASK};
        end
      end else if (tag_at(12, TAG_VP8L)) begin
        if (end_pos >= 24 && probe_hdr[20] == VP8L_SIG) begin
          bits = le_at(21, 4);
          r.image_kind   = KIND_WEBP;
          r.pixel_width  = {18'h0, bits[13:0]} + 32'd1;
          r.pixel_height = {18'h0, bits[27:14]} + 32'd1;
        end
      end else if (tag_at(12, TAG_VP8X) && end_pos >= 29) begin
        r.image_kind   = KIND_WEBP;
        r.pixel_width  = le_at(24, 3) + 32'd1;
        r.pixel_height = le_at(27, 3) + 32'd1;
      end
    end
    return r;
  endfunction

  function automatic void sniff_byte(in_word_t w);
    if (probe_pos >= 2) walk_marker_byte(w.data_byte);
    if (probe_pos < STORE_DEPTH) probe_hdr[probe_pos[STORE_IDX_BITS-1:0]] = w.data_byte;
    if (!w.end_of_file) begin
      if (probe_pos != '1) probe_pos = probe_pos + 32'd1;
    end else begin
      expected_sizes.push_back(classify_header(probe_pos));
      clear_file_state();
    end
  endfunction

  // ---------------- file builders ----------------

  task automatic put(logic [7:0] b);
    file_q.push_back(b);
  endtask

  task automatic put_be(logic [31:0] v, int n);
    for (int i = n - 1; i >= 0; i--) put(v[8 * i +: 8]);
  endtask

  task automatic put_le(logic [31:0] v, int n);
    for (int i = 0; i < n; i++) put(v[8 * i +: 8]);
  endtask

  task automatic put_noise(int n);
    repeat (n) put(8'($urandom_range(0, 255)));
  endtask

  function automatic logic [31:0] pick_dim(int nbits);
    logic [31:0] mask;
    mask = (nbits >= 32) ? 32'hffff_ffff : ((32'd1 << nbits) - 32'd1);
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return mask;
      2: return 32'($urandom_range(1, 64));
      default: return $urandom() & mask;
    endcase
  endfunction

  task automatic build_png(logic [31:0] w, logic [31:0] h, int tail);
    put_be(SIG_PNG[63:32], 4);
    put_be(SIG_PNG[31:0], 4);
    put_be(($urandom_range(0, 3) == 0) ? $urandom() : 32'd13, 4);
    put_be(TAG_IHDR, 4);
    put_be(w, 4);
    put_be(h, 4);
    put_noise(tail);
  endtask

  task automatic build_gif();
    put_be(TAG_GIF8, 4);
    if ($urandom_range(0, 9) == 0) put(8'($urandom_range(0, 255)));
    else put($urandom_range(0, 1) ? GIF_VER9 : GIF_VER7);
    put(GIF_LET_A);
    put_le(pick_dim(16), 2);
    put_le(pick_dim(16), 2);
    put_noise($urandom_range(0, 4));
  endtask

  task automatic build_webp();
    put_be(TAG_RIFF, 4);
    put_noise(4);
    put_be(TAG_WEBP, 4);
    case ($urandom_range(0, 3))
      0: begin
        put_be(TAG_VP8, 4);
        put_noise(7);
        put_be({8'h00, VP8_START}, 3);
        put_le(pick_dim(16), 2);
        put_le(pick_dim(16), 2);
      end
      1: begin
        put_be(TAG_VP8L, 4);
        put_noise(4);
        put(VP8L_SIG);
        put_le(pick_dim(32), 4);
      end
      2: begin
        put_be(TAG_VP8X, 4);
        put_noise(8);
        put_le(pick_dim(24), 3);
        put_le(pick_dim(24), 3);
      end
      default: begin
        put_be($urandom(), 4);
        put_noise(14);
      end
    endcase
    put_noise($urandom_range(0, 3));
  endtask

  task automatic build_jpeg();
    logic [7:0] m;
    logic [15:0] seg_len;
    int r;
    put(JPG_FILL);
    put(JPG_SOI);
    repeat ($urandom_range(0, 3)) begin
      repeat ($urandom_range(0, 1)) put(JPG_FILL);
      put(JPG_FILL);
      case ($urandom_range(0, 7))
        0: m = JPG_RST0 + 8'($urandom_range(0, 9));
        1: m = JPG_TEM;
        2: m = JPG_DHT;
        3: m = JPG_JPG;
        4: m = JPG_DAC;
        5: m = JPG_APP0 + 8'($urandom_range(0, 15));
        default: m = 8'($urandom_range(0, 254));
      endcase
      put(m);
      if (!is_standalone(m)) begin
        r = $urandom_range(0, 31);
        if (r < 2) seg_len = 16'(r);
        else if (r == 2) seg_len = 16'h0100;
        else seg_len = 16'($urandom_range(2, 8));
        put_be({16'h0, seg_len}, 2);
        if (seg_len >= 16'd2) put_noise(seg_len - 16'd2);
      end
    end
    // a stray byte where a marker must start
    if ($urandom_range(0, 15) == 0) put(8'($urandom_range(0, 254)));
    put(JPG_FILL);
    m = JPG_SOF0 + 8'($urandom_range(0, 15));
    if (!is_frame_marker(m)) m = JPG_SOFF;
    put(m);
    seg_len = ($urandom_range(0, 15) == 0) ? 16'($urandom_range(0, 1))
                                           : 16'($urandom_range(8, 17));
    put_be({16'h0, seg_len}, 2);
    put(8'($urandom_range(0, 255)));
    put_be(pick_dim(16), 2);
    put_be(pick_dim(16), 2);
    put_noise($urandom_range(0, 3));
  endtask

  task automatic close_file(bit clean);
    int keep;
    int idx;
    in_word_t w;
    if (file_q.size() == 0) put(8'($urandom_range(0, 255)));
    if (!clean) begin
      if ($urandom_range(0, 1) == 0) begin
        idx = $urandom_range(0, file_q.size() - 1);
        file_q[idx] = file_q[idx] ^ 8'($urandom_range(1, 255));
      end else begin
        keep = $urandom_range(1, file_q.size());
        while (file_q.size() > keep) void'(file_q.pop_back());
      end
    end
    foreach (file_q[k]) begin
      w.data_byte   = file_q[k];
      w.end_of_file = (k == file_q.size() - 1);
      pending_bytes.push_back(w);
    end
    file_q.delete();
    file_count++;
  endtask

  task automatic build_random_file();
    case ($urandom_range(0, 11))
      0, 1:    build_png(pick_dim(32), pick_dim(32), $urandom_range(0, 6));
      2, 3, 4: build_jpeg();
      5, 6:    build_gif();
      7, 8, 9: build_webp();
      10:      put_noise($urandom_range(1, 40));
      default: begin
        if ($urandom_range(0, 1)) put(JPG_FILL);
        put_noise($urandom_range(0, 2));
      end
    endcase
    close_file($urandom_range(0, 99) < 75);
  endtask

  // ---------------- handshakes ----------------

  function automatic int load_stage();
    return (in_accepted * 3) / in_total;
  endfunction

  function automatic logic sender_idles();
    case (load_stage())
      0: return $urandom_range(0, 99) < 38;
      1: return $urandom_range(0, 99) < 82;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic receiver_stalls();
    case (load_stage())
      0: return $urandom_range(0, 99) < 82;
      1: return $urandom_range(0, 99) < 38;
      default: return 1'b0;
    endcase
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        sniff_byte(in_word);
        in_accepted <= in_accepted + 1;
      end
      if (!in_valid || !in_stall) begin
        if (pending_bytes.size() != 0 && !sender_idles()) begin
          in_word  <= pending_bytes.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_accepted <= out_accepted + 1;
        if (expected_sizes.size() == 0) begin
          report_mismatch($sformatf("result word with no file pending (kind %0d)",
                                    out_word.image_kind));
        end else begin
          want = expected_sizes.pop_front();
          kinds_seen[want.image_kind]++;
          if (out_word.image_kind !== want.image_kind)
            report_mismatch($sformatf("file %0d kind %0d, want %0d", out_accepted,
                                      out_word.image_kind, want.image_kind));
          if (out_word.pixel_width !== want.pixel_width)
            report_mismatch($sformatf("file %0d width %0h, want %0h", out_accepted,
                                      out_word.pixel_width, want.pixel_width));
          if (out_word.pixel_height !== want.pixel_height)
            report_mismatch($sformatf("file %0d height %0h, want %0h", out_accepted,
                                      out_word.pixel_height, want.pixel_height));
        end
      end
      out_stall <= receiver_stalls();
    end
  end

  // watchdog on cycles without any word moving
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("[%0t] no word moved for %0d cycles", $time, QUIET_LIMIT);
        $display("Some tests failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    // png with extreme sizes, long enough to fill the whole header store
    build_png(32'hffff_ffff, 32'h0000_0000, 6);
    close_file(1'b1);
    // single-byte file
    put(8'h00);
    close_file(1'b1);
    // jpeg: fill run, standalone marker, empty segment, frame with max sizes
    put(JPG_FILL);
    put(JPG_SOI);
    put(JPG_FILL);
    put(JPG_FILL);
    put(JPG_EOI);
    put(JPG_FILL);
    put(JPG_DHT);
    put_be(32'd2, 2);
    put(JPG_FILL);
    put(JPG_SOFF);
    put_be(32'd8, 2);
    put(8'd8);
    put_be(32'hffff, 2);
    put_be(32'hffff, 2);
    close_file(1'b1);

    while (pending_bytes.size() < 850) build_random_file();
    in_total = pending_bytes.size();

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    do @(negedge clk);
    while (pending_bytes.size() != 0 || in_valid || expected_sizes.size() != 0);
    repeat (8) @(negedge clk);

    if (expected_sizes.size() != 0)
      report_mismatch($sformatf("%0d result words never arrived", expected_sizes.size()));
    $display("checked %0d of %0d files over %0d bytes", out_accepted, file_count,
             in_accepted);
    $display("png %0d, jpeg %0d, gif %0d, webp %0d, unrecognized %0d",
             kinds_seen[KIND_PNG], kinds_seen[KIND_JPEG], kinds_seen[KIND_GIF],
             kinds_seen[KIND_WEBP], kinds_seen[KIND_NONE]);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[image_header_size_probe_top.f]
rtl/ihsp_pkg.sv
rtl/ihsp_walker.sv
rtl/ihsp_classify.sv
rtl/image_header_size_probe_top.sv
bench/image_header_size_probe_top_test.sv
